// ----- rtl/core/mwvq_pkg.sv -----
// ----------------------------------------------------------------------------
// mwvq_pkg
// shared widths, codes and types of the min-weight vertex queue
// ----------------------------------------------------------------------------
package mwvq_pkg;

  // field widths of the stream items
  localparam int OP_W  = 3;
  localparam int VTX_W = 6;
  localparam int WGT_W = 32;
  localparam int ST_W  = 3;
  localparam int CNT_W = 7;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  // defaults of the top level parameters
  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 32;

  localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_UPDATE = 3'd1,
    OP_REMOVE = 3'd2,
    OP_EXISTS = 3'd3,
    OP_POP    = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  // one command as taken from the input stream
  typedef struct packed {
    op_t              op;
    logic [VTX_W-1:0] vertex;
    logic [WGT_W-1:0] weight;
  } cmd_t;

  // one result as handed to the output register
  typedef struct packed {
    status_t          status;
    logic             present;
    logic [VTX_W-1:0] result_vertex;
  } res_t;

endpackage

// ----- rtl/core/min_weight_vertex_queue.sv -----
// ----------------------------------------------------------------------------
// min_weight_vertex_queue
// indexed min-priority queue of vertices kept as an unordered list in memory
// ----------------------------------------------------------------------------
// usage
// - commands come in on s_tvalid/s_tready/s_tdata: insert, update weight,
//   remove, exists query and pop minimum; every command gives one result
//   item on m_tvalid/m_tready/m_tdata with a status code
// - cfg_wen/cfg_wdata set the number of vertices in use (reset 64); write
//   it only while no command is in flight
// - one command is worked on at a time; s_tready rises again once its result
//   sits in the output register, so the next command is taken while that
//   result still waits for the receiver
// - insert, update, out-of-range and unknown codes, and remove or pop on an
//   empty list go straight from decode to the result; exists reads the
//   weight store first; remove and pop otherwise scan the whole list through
//   the single read port of the list memory, one entry a cycle, with the
//   weight memory read of each entry pipelined behind it
// - reset empties the list and marks every weight absent at once through
//   per-vertex written flags; no clearing pass is needed
// - a stalled receiver holds the result in the output register; the engine
//   then waits with its next result until the register frees up
// ----------------------------------------------------------------------------
module min_weight_vertex_queue #(
  parameter int MAX_VERTICES = mwvq_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = mwvq_pkg::WEIGHT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // fields from bit 0: operation[2:0], vertex[8:3], weight[40:9], zero fill
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [mwvq_pkg::IN_TDATA_W-1:0]  s_tdata,
  // fields from bit 0: result_vertex[5:0], present[6], status[9:7], zero fill
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [mwvq_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             cfg_wen,
  input  logic [mwvq_pkg::CNT_W-1:0]       cfg_wdata
);
  import mwvq_pkg::*;

  logic [CNT_W-1:0] vertex_count;
  cmd_t             cmd;
  res_t             res;
  logic             res_valid;
  logic             res_ready;

  // vertex count register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (cfg_wen) begin
      vertex_count <= cfg_wdata;
    end
  end

  // unpack the command item
  always_comb begin
    cmd.op     = op_t'(s_tdata[OP_W-1:0]);
    cmd.vertex = s_tdata[OP_W +: VTX_W];
    cmd.weight = s_tdata[OP_W + VTX_W +: WGT_W];
  end

  mwvq_engine #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_count (vertex_count),
    .cmd_valid (s_tvalid),
    .cmd_ready (s_tready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {{(OUT_TDATA_W - ST_W - 1 - VTX_W){1'b0}},
                  res.status, res.present, res.result_vertex};
    end
  end

endmodule

// ----- rtl/core/mwvq_engine.sv -----
// ----------------------------------------------------------------------------
// mwvq_engine
// sequencer around the vertex list and weight memories: decodes one command,
// scans the list through a three-stage read pipeline and writes back
// ----------------------------------------------------------------------------
module mwvq_engine #(
  parameter int MAX_VERTICES = mwvq_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = mwvq_pkg::WEIGHT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [mwvq_pkg::CNT_W-1:0] cfg_count,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  mwvq_pkg::cmd_t             cmd,
  output logic                       res_valid,
  input  logic                       res_ready,
  output mwvq_pkg::res_t             res
);
  import mwvq_pkg::*;

  // list addressing and the weight store, which only vertex indices can reach
  localparam int LAW   = $clog2(MAX_VERTICES);
  localparam int LENW  = $clog2(MAX_VERTICES + 1);
  localparam int WDEPTH = (MAX_VERTICES < (1 << VTX_W)) ? MAX_VERTICES : (1 << VTX_W);
  localparam int WAW   = $clog2(WDEPTH);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EXEC  = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_DRAIN = 9'b000001000,
    S_LAST  = 9'b000010000,
    S_DROP  = 9'b000100000,
    S_XRD   = 9'b001000000,
    S_XCHK  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  // latched command
  op_t                    op_q;
  logic [VTX_W-1:0]       vtx_q;
  logic [WEIGHT_BITS-1:0] wt_q;

  logic [LENW-1:0] len;
  logic [LENW-1:0] lenm1;

  // memories
  logic [VTX_W-1:0]       list_mem [MAX_VERTICES];
  logic [WEIGHT_BITS-1:0] weight_mem [WDEPTH];
  logic [WDEPTH-1:0]      wvalid;

  logic [VTX_W-1:0]       list_rdata;
  logic [WEIGHT_BITS-1:0] weight_rdata;
  logic                   wvalid_q;

  logic                   list_we;
  logic [LAW-1:0]         list_waddr;
  logic [VTX_W-1:0]       list_wdata;
  logic [LAW-1:0]         list_raddr;
  logic                   wt_we;
  logic [WAW-1:0]         weight_raddr;

  // scan pipeline
  logic [LAW-1:0]         scan_addr;
  logic                   s1_valid;
  logic [LAW-1:0]         s1_pos;
  logic                   s2_valid;
  logic [LAW-1:0]         s2_pos;
  logic [VTX_W-1:0]       s2_vtx;
  logic [WEIGHT_BITS-1:0] cw;

  logic                   found;
  logic [LAW-1:0]         best_pos;
  logic [VTX_W-1:0]       best_vtx;
  logic [WEIGHT_BITS-1:0] best_wt;

  logic oor;
  logic full;
  logic ins_ok;
  logic upd_ok;

  // decode of the latched command
  assign lenm1  = len - LENW'(1);
  assign oor    = ({1'b0, vtx_q} >= cfg_count) || (32'(vtx_q) >= 32'(MAX_VERTICES));
  assign full   = (len == LENW'(MAX_VERTICES));
  assign ins_ok = (op_q == OP_INSERT) && !oor && !full;
  assign upd_ok = (op_q == OP_UPDATE) && !oor;
  assign cw     = wvalid_q ? weight_rdata : '1;

  assign cmd_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  // memory port control
  always_comb begin
    list_we      = ((state == S_EXEC) && ins_ok) || (state == S_DROP);
    list_waddr   = (state == S_DROP) ? best_pos : len[LAW-1:0];
    list_wdata   = (state == S_DROP) ? list_rdata : vtx_q;
    list_raddr   = (state == S_LAST) ? lenm1[LAW-1:0] : scan_addr;
    wt_we        = (state == S_EXEC) && (ins_ok || upd_ok);
    weight_raddr = (state == S_XRD) ? vtx_q[WAW-1:0] : list_rdata[WAW-1:0];
  end

  // vertex list memory
  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    list_rdata <= list_mem[list_raddr];
  end

  // weight memory, with the written flag read alongside
  always_ff @(posedge clk) begin
    if (wt_we) begin
      weight_mem[vtx_q[WAW-1:0]] <= wt_q;
    end
    weight_rdata <= weight_mem[weight_raddr];
    wvalid_q     <= wvalid[weight_raddr];
  end

  // written flags: an unwritten or dropped vertex reads as absent
  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
    end else begin
      if (wt_we) begin
        wvalid[vtx_q[WAW-1:0]] <= 1'b1;
      end
      if (state == S_DROP) begin
        wvalid[best_vtx[WAW-1:0]] <= 1'b0;
      end
    end
  end

  // scan pipeline stages and best-entry tracking
  always_ff @(posedge clk) begin
    s1_pos <= scan_addr;
    s2_pos <= s1_pos;
    s2_vtx <= list_rdata;
    if (state == S_EXEC) begin
      found <= 1'b0;
    end else if (s2_valid) begin
      if (op_q == OP_POP) begin
        if (!found || (cw < best_wt)) begin
          found    <= 1'b1;
          best_pos <= s2_pos;
          best_vtx <= s2_vtx;
          best_wt  <= cw;
        end
      end else if (!found && (s2_vtx == vtx_q)) begin
        found    <= 1'b1;
        best_pos <= s2_pos;
        best_vtx <= s2_vtx;
      end
    end
  end

  // sequencer; result fields start cleared for each command
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      len      <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= (state == S_SCAN);
      s2_valid <= s1_valid;
      unique case (state)
        S_IDLE: begin
          res.result_vertex <= '0;
          res.present       <= 1'b0;
          res.status        <= ST_OK;
          if (cmd_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          if ((op_q == OP_INSERT || op_q == OP_UPDATE || op_q == OP_REMOVE ||
               op_q == OP_EXISTS) && oor) begin
            res.status <= ST_RANGE;
          end else begin
            case (op_q)
              OP_INSERT: begin
                if (full) begin
                  res.status <= ST_FULL;
                end else begin
                  len <= len + LENW'(1);
                end
              end
              OP_REMOVE: begin
                if (len == '0) begin
                  res.status <= ST_NOT_FOUND;
                end else begin
                  state <= S_SCAN;
                end
              end
              OP_POP: begin
                if (len == '0) begin
                  res.status <= ST_EMPTY;
                end else begin
                  state <= S_SCAN;
                end
              end
              OP_EXISTS: state <= S_XRD;
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_addr == lenm1[LAW-1:0]) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!s1_valid && !s2_valid) begin
            if (found) begin
              state <= S_LAST;
            end else begin
              res.status <= ST_NOT_FOUND;
              state      <= S_DONE;
            end
          end
        end
        S_LAST: state <= S_DROP;
        S_DROP: begin
          len   <= lenm1;
          state <= S_DONE;
          if (op_q == OP_POP) begin
            res.result_vertex <= best_vtx;
          end
        end
        S_XRD: state <= S_XCHK;
        S_XCHK: begin
          res.present <= wvalid_q && (weight_rdata != '1);
          state       <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // command latch and scan address
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      op_q  <= cmd.op;
      vtx_q <= cmd.vertex;
      wt_q  <= WEIGHT_BITS'(cmd.weight);
    end
    if (state == S_EXEC) begin
      scan_addr <= '0;
    end else if (state == S_SCAN) begin
      scan_addr <= scan_addr + LAW'(1);
    end
  end

endmodule

// ----- rtl/core/mwvq_checker.sv -----
// ----------------------------------------------------------------------------
// mwvq_checker
// port-level checks of the result stream of the vertex queue
// ----------------------------------------------------------------------------
module mwvq_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [mwvq_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import mwvq_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no result straight after reset
  assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result shown right after reset");

  // present is only reported together with status ok
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[VTX_W] |-> m_tdata[VTX_W+1 +: ST_W] == ST_OK)
    else $error("present set with a failing status");

  // a popped vertex only comes with status ok and without present
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[VTX_W-1:0] != '0) |->
      (m_tdata[VTX_W+1 +: ST_W] == ST_OK) && !m_tdata[VTX_W])
    else $error("result vertex on a failed or non-pop item");

endmodule

bind min_weight_vertex_queue mwvq_checker u_mwvq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the min-weight vertex queue. A shadow copy of the
// vertex list, weight store and vertex count predicts every reply; replies
// are compared field by field against that prediction, in order. Both stream
// sides idle and stall at random, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import mwvq_pkg::*;

  localparam int                NUM_VTX     = MAX_VERTICES_DEF;
  localparam logic [WGT_W-1:0]  WGT_ABSENT  = '1;
  localparam logic [WGT_W-1:0]  WGT_TOP     = WGT_ABSENT - 1'b1;
  localparam int                GAP_MAX     = 13;
  localparam int                DRAIN_WAIT  = 80;
  localparam int                HOLD_CYCLES = 400;
  localparam int                PAD_W       = IN_TDATA_W - OP_W - VTX_W - WGT_W;

  logic                   clk;
  logic                   rst;
  // fields from bit 0: operation[2:0], vertex[8:3], weight[40:9], zero fill
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  // fields from bit 0: result_vertex[5:0], present[6], status[9:7], zero fill
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_wen;
  logic [CNT_W-1:0]       cfg_wdata;

  // shadow state of the queue
  logic [VTX_W-1:0] shadow_list [NUM_VTX];
  logic [WGT_W-1:0] shadow_weight [NUM_VTX];
  int unsigned      shadow_len;
  int unsigned      shadow_vcount;

  res_t replies_due[$];
  int   errors;
  int   tx_gap_max;
  int   rx_gap_max;
  int   rx_hold;

  min_weight_vertex_queue DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #12_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned vertex_limit();
    return (shadow_vcount < NUM_VTX) ? shadow_vcount : NUM_VTX;
  endfunction

  // mark the listed vertex absent and fill its slot with the last entry
  function automatic void drop_slot(int unsigned pos);
    shadow_weight[shadow_list[pos]] = WGT_ABSENT;
    shadow_list[pos] = shadow_list[shadow_len - 1];
    shadow_len--;
  endfunction

  // one command against the shadow state, giving the reply it should cause
  function automatic res_t vertex_queue_step(logic [OP_W-1:0] op, logic [VTX_W-1:0] vtx,
                                             logic [WGT_W-1:0] wgt);
    res_t             r;
    int unsigned      best;
    logic [WGT_W-1:0] best_w;
    r = '0;
    r.status = ST_OK;
    if (op <= OP_EXISTS && vtx >= vertex_limit()) begin
      r.status = ST_RANGE;
    end else begin
      case (op)
        OP_INSERT: begin
          if (shadow_len >= NUM_VTX) begin
            r.status = ST_FULL;
          end else begin
            shadow_list[shadow_len] = vtx;
            shadow_len++;
            shadow_weight[vtx] = wgt;
          end
        end
        OP_UPDATE: begin
          shadow_weight[vtx] = wgt;
        end
        OP_REMOVE: begin
          r.status = ST_NOT_FOUND;
          for (int unsigned i = 0; i < shadow_len; i++) begin
            if (shadow_list[i] == vtx) begin
              drop_slot(i);
              r.status = ST_OK;
              break;
            end
          end
        end
        OP_EXISTS: begin
          r.present = (shadow_weight[vtx] != WGT_ABSENT);
        end
        OP_POP: begin
          if (shadow_len == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // strictly smaller wins, so the earliest slot keeps a tie
            best = 0;
            best_w = shadow_weight[shadow_list[0]];
            for (int unsigned i = 1; i < shadow_len; i++) begin
              if (shadow_weight[shadow_list[i]] < best_w) begin
                best_w = shadow_weight[shadow_list[i]];
                best = i;
              end
            end
            r.result_vertex = shadow_list[best];
            drop_slot(best);
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // weights: extremes, a narrow band for ties, and full-range values
  function automatic logic [WGT_W-1:0] pick_weight();
    logic [WGT_W-1:0] w;
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = WGT_TOP;
      2, 3, 4: w = WGT_W'($urandom_range(0, 15));
      default: begin
        w = WGT_W'($urandom);
        if (w == WGT_ABSENT) w = WGT_TOP;
      end
    endcase
    return w;
  endfunction

  // mostly in range, now and then anywhere in the field
  function automatic logic [VTX_W-1:0] pick_vertex();
    if ($urandom_range(0, 9) == 0) return VTX_W'($urandom);
    return VTX_W'($urandom_range(0, vertex_limit() - 1));
  endfunction

  // send one item; the reply is predicted at the edge that accepts it
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [VTX_W-1:0] vtx,
                          input logic [WGT_W-1:0] wgt);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_W{1'b0}}, wgt, vtx, op};
    do @(posedge clk); while (s_tready !== 1'b1);
    replies_due.push_back(vertex_queue_step(op, vtx, wgt));
  endtask

  // random command, often aimed at a vertex that sits in the list
  task automatic send_random_cmd(input int insert_pct);
    int               pick;
    logic [OP_W-1:0]  op;
    logic [VTX_W-1:0] vtx;
    vtx = pick_vertex();
    pick = $urandom_range(0, 99);
    if (pick < insert_pct) begin
      op = OP_INSERT;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 35) op = OP_POP;
      else if (pick < 60) op = OP_REMOVE;
      else if (pick < 80) op = OP_UPDATE;
      else op = OP_EXISTS;
    end
    if (op != OP_INSERT && op != OP_POP && shadow_len > 0 && $urandom_range(0, 2) != 0) begin
      vtx = shadow_list[$urandom_range(0, shadow_len - 1)];
    end
    send_cmd(op, vtx, pick_weight());
  endtask

  // let every reply come back, then allow for the longest scan
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int unsigned cnt);
    cfg_wen   <= 1'b1;
    cfg_wdata <= CNT_W'(cnt);
    @(posedge clk);
    cfg_wen <= 1'b0;
    shadow_vcount = cnt;
  endtask

  task automatic pick_idling();
    tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
    rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
  endtask

  // empty pop, not found, ties, repeated insert, reserved weight, unknown codes
  task automatic test_directed_cases();
    tx_gap_max = GAP_MAX;
    rx_gap_max = GAP_MAX;
    send_cmd(OP_POP, '0, '0);
    send_cmd(OP_REMOVE, VTX_W'(3), '0);
    send_cmd(OP_EXISTS, '0, '0);
    send_cmd(OP_INSERT, '0, '0);
    send_cmd(OP_INSERT, '1, WGT_TOP);
    send_cmd(OP_INSERT, VTX_W'(5), WGT_W'(7));
    send_cmd(OP_EXISTS, '1, '0);
    send_cmd(OP_UPDATE, VTX_W'(5), '0);
    send_cmd(OP_UPDATE, VTX_W'(9), WGT_W'(3));
    send_cmd(OP_EXISTS, VTX_W'(9), '0);
    send_cmd(OP_INSERT, VTX_W'(5), WGT_W'(100));
    send_cmd(OP_REMOVE, VTX_W'(5), '0);
    send_cmd(OP_EXISTS, VTX_W'(5), '0);
    send_cmd(OP_INSERT, VTX_W'(7), WGT_ABSENT);
    send_cmd(OP_EXISTS, VTX_W'(7), '0);
    for (int c = int'(OP_POP) + 1; c < (1 << OP_W); c++) begin
      send_cmd(OP_W'(c), '1, WGT_ABSENT);
    end
    repeat (4) send_cmd(OP_POP, '1, WGT_ABSENT);
    send_cmd(OP_POP, '0, '0);
    wait_idle();
  endtask

  // narrow vertex count: every insert, update, remove or exists at or above it is rejected
  task automatic test_vertex_limit();
    set_vertex_count(5);
    send_cmd(OP_INSERT, VTX_W'(4), WGT_W'(11));
    send_cmd(OP_INSERT, VTX_W'(5), WGT_W'(1));
    send_cmd(OP_UPDATE, VTX_W'(5), WGT_W'(1));
    send_cmd(OP_REMOVE, '1, '0);
    send_cmd(OP_EXISTS, VTX_W'(5), '0);
    send_cmd(OP_EXISTS, VTX_W'(4), '0);
    send_cmd(OP_POP, '1, '0);
    wait_idle();
  endtask

  task automatic test_random(input int count, input int insert_pct);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) pick_idling();
      send_random_cmd(insert_pct);
    end
    wait_idle();
  endtask

  // fill to the top, one insert too many, eight updates, then pop everything in weight order and once more on empty
  task automatic test_fill_and_drain();
    pick_idling();
    while (shadow_len < NUM_VTX) send_cmd(OP_INSERT, pick_vertex(), pick_weight());
    send_cmd(OP_INSERT, pick_vertex(), pick_weight());
    repeat (8) send_cmd(OP_UPDATE, shadow_list[$urandom_range(0, NUM_VTX - 1)], pick_weight());
    pick_idling();
    while (shadow_len > 0) send_cmd(OP_POP, VTX_W'($urandom), WGT_W'($urandom));
    send_cmd(OP_POP, '0, '0);
    wait_idle();
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    tx_gap_max = 0;
    rx_gap_max = 0;
    rx_hold = HOLD_CYCLES;
    repeat (40) send_random_cmd(40);
    wait_idle();
  endtask

  // sequence of tests
  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_wen   <= 1'b0;
    cfg_wdata <= '0;
    errors = 0;
    rx_hold = 0;
    tx_gap_max = 0;
    rx_gap_max = 0;
    shadow_len = 0;
    shadow_vcount = VCOUNT_RESET;
    for (int i = 0; i < NUM_VTX; i++) begin
      shadow_list[i] = '0;
      shadow_weight[i] = WGT_ABSENT;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_vertex_limit();
    set_vertex_count(64);
    test_random(300, 55);
    test_fill_and_drain();
    set_vertex_count(1);
    test_random(100, 40);
    set_vertex_count(2);
    test_random(100, 40);
    set_vertex_count(17);
    test_random(250, 45);
    set_vertex_count(64);
    test_backpressure();
    set_vertex_count(33);
    test_random(300, 45);
    set_vertex_count(63);
    test_random(300, 50);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver: random stalls per item, and check each reply in order
  initial begin
    int   stall;
    res_t got;
    res_t want;
    m_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end else begin
        stall = $urandom_range(0, rx_gap_max);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      got = res_t'(m_tdata[$bits(res_t)-1:0]);
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, actual %h", $time, m_tdata);
      end else begin
        want = replies_due.pop_front();
        if (got.result_vertex !== want.result_vertex) begin
          errors++;
          $display("%0t: result_vertex mismatch, expected %0d, actual %0d",
                   $time, want.result_vertex, got.result_vertex);
        end
        if (got.present !== want.present) begin
          errors++;
          $display("%0t: present mismatch, expected %0d, actual %0d",
                   $time, want.present, got.present);
        end
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, got.status);
        end
      end
    end
  end

endmodule

// ----- filelist.f -----
rtl/core/mwvq_pkg.sv
rtl/core/mwvq_engine.sv
rtl/core/min_weight_vertex_queue.sv
rtl/core/mwvq_checker.sv
test/tb_top.sv
